// File: sv/rsqm_pkg.sv
package rsqm_pkg;

  typedef enum logic [1:0] {
    OP_RX     = 2'd0,
    OP_GAP    = 2'd1,
    OP_STATUS = 2'd2,
    OP_TICK   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    EV_QUALITY = 2'd0,
    EV_LOSS    = 2'd1,
    EV_JITTER  = 2'd2
  } ev_kind_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN, ST_M5_GO, ST_LVL, ST_LM_GO, ST_LM_WAIT,
    ST_LD_GO, ST_LD_WAIT, ST_JM_GO, ST_JM_WAIT, ST_EMIT
  } bst_t;

  typedef struct packed {
    op_t                op;
    logic [31:0]        ssrc;
    logic signed [15:0] jitter;
    logic [15:0]        gap;
    logic [15:0]        seq;
    logic [2:0]         status;
  } item_t;

  localparam logic [1:0]  CFG_JIT_THR  = 2'd0;
  localparam logic [1:0]  CFG_JIT_PER  = 2'd1;
  localparam logic [1:0]  CFG_LOSS_THR = 2'd2;
  localparam logic [1:0]  CFG_LOSS_PER = 2'd3;

  localparam int          DIV_NW         = 48;
  localparam int          DIV_DW         = 33;
  localparam int          SEQ_LIST_LIMIT = 500;
  localparam logic [31:0] INACT_TICK     = 32'd5;
  localparam logic [2:0]  QUALITY_PERIOD = 3'd5;
  localparam logic [2:0]  LEVEL_UNSET    = 3'd7;
  localparam logic [22:0] JITTER_MAX     = 23'h7FFFFF;
  localparam logic [14:0] LOSS_SCALE     = 15'd25600;
  localparam logic [2:0]  FST_OTHER      = 3'd4;

endpackage

// File: sv/rsqm_front.sv
module rsqm_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [1:0]     in_opcode,
  input  logic [31:0]    in_packet_ssrc,
  input  logic signed [15:0] in_packet_jitter,
  input  logic [15:0]    in_gap_count,
  input  logic [15:0]    in_seq_number,
  input  logic [2:0]     in_frame_status,
  output logic           itm_valid,
  input  logic           itm_pop,
  output rsqm_pkg::item_t itm
);
  import rsqm_pkg::*;

  item_t      q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;

  assign in_stall  = (cnt_r == 2'd2);
  assign push      = in_valid && !in_stall;
  assign itm_valid = (cnt_r != 2'd0);
  assign itm       = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r].op     <= op_t'(in_opcode);
      q_r[wp_r].ssrc   <= in_packet_ssrc;
      q_r[wp_r].jitter <= in_packet_jitter;
      q_r[wp_r].gap    <= in_gap_count;
      q_r[wp_r].seq    <= in_seq_number;
      q_r[wp_r].status <= in_frame_status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (itm_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, itm_pop};
    end
  end

endmodule

// File: sv/rsqm_div.sv
module rsqm_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [rsqm_pkg::DIV_NW-1:0] dividend,
  input  logic [rsqm_pkg::DIV_DW-1:0] divisor,
  output logic                        done,
  output logic [rsqm_pkg::DIV_NW-1:0] quo,
  output logic [rsqm_pkg::DIV_DW-1:0] rem
);
  import rsqm_pkg::*;

  localparam int CW = $clog2(DIV_NW);

  logic [DIV_DW-1:0] rem_r, dvs_r;
  logic [DIV_NW-1:0] quo_r;
  logic [CW-1:0]     cnt_r;
  logic              busy_r, done_r;
  logic [DIV_DW:0]   sh, diff;
  logic              ge;

  // one quotient bit a cycle, restoring
  assign sh   = {rem_r, quo_r[DIV_NW-1]};
  assign ge   = sh >= {1'b0, dvs_r};
  assign diff = sh - {1'b0, dvs_r};
  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DIV_DW-1:0] : sh[DIV_DW-1:0];
      quo_r <= {quo_r[DIV_NW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(DIV_NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// File: sv/rsqm_back.sv
module rsqm_back #(
  parameter int SEQ_STORE_DEPTH = 512
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            itm_valid,
  output logic            itm_pop,
  input  rsqm_pkg::item_t itm,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_index,
  input  logic [15:0]     cfg_wdata,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [1:0]      out_event_kind,
  output logic [2:0]      out_quality_level,
  output logic            out_inactivity,
  output logic [14:0]     out_loss_percent,
  output logic [22:0]     out_jitter_average,
  output logic            out_last
);
  import rsqm_pkg::*;

  localparam int KEEP = (SEQ_LIST_LIMIT - 1 < SEQ_STORE_DEPTH) ? SEQ_LIST_LIMIT - 1
                                                              : SEQ_STORE_DEPTH;
  localparam int AW   = (SEQ_STORE_DEPTH > 1) ? $clog2(SEQ_STORE_DEPTH) : 1;
  localparam int FW   = $clog2(KEEP + 1);

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    return (p == '0) ? AW'(SEQ_STORE_DEPTH - 1) : p - 1'b1;
  endfunction

  bst_t        st_r, st_nxt;
  logic [15:0] cur_seq_r, cur_seq_nxt;
  logic [2:0]  cur_status_r, cur_status_nxt;
  logic        ssrc_valid_r, ssrc_valid_nxt;
  logic [31:0] ssrc_r, ssrc_nxt;
  logic [22:0] ewma_r, ewma_nxt;
  logic [31:0] total_r, total_nxt, win_rx_r, win_rx_nxt, win_lost_r, win_lost_nxt;
  logic [31:0] chk_rx_r, chk_rx_nxt, chk_lost_r, chk_lost_nxt, tick_r, tick_nxt;
  logic [2:0]  m5_r, m5_nxt;
  logic [2:0]  level_r, level_nxt, ev_lvl0_r, ev_lvl0_nxt;
  logic        inact_r, inact_nxt, ev_in0_r, ev_in0_nxt;
  logic [AW-1:0] head_r, head_nxt, scan_p_r, scan_p_nxt;
  logic [FW-1:0] fill_r, fill_nxt, scan_k_r, scan_k_nxt;
  logic        scan_pv_r, scan_pv_nxt;
  logic [3:0]  ev_r, ev_nxt;
  logic [38:0] l100_r, l100_nxt;
  logic [32:0] tot_r, tot_nxt;
  logic [14:0] pct_r, pct_nxt;
  logic [15:0] jthr_r, jthr_nxt, jper_r, jper_nxt, lper_r, lper_nxt;
  logic [6:0]  lthr_r, lthr_nxt;
  logic        out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  logic [1:0]  out_kind_r, out_kind_nxt;
  logic [2:0]  out_lvl_r, out_lvl_nxt;
  logic        out_inact_r, out_inact_nxt;
  logic [14:0] out_loss_r, out_loss_nxt;
  logic [22:0] out_jit_r, out_jit_nxt;

  logic [15:0]       seq_mem [SEQ_STORE_DEPTH];
  logic [15:0]       rd_q;
  logic              mem_we;
  logic [AW-1:0]     mem_wa;

  logic              div_start, div_done;
  logic [DIV_NW-1:0] div_nd, div_quo;
  logic [DIV_DW-1:0] div_ds, div_rem;
  logic [46:0]       loss_prod;

  assign loss_prod = chk_lost_r * LOSS_SCALE;

  rsqm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_nd),
    .divisor  (div_ds),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  always_ff @(posedge clk) begin
    if (mem_we) seq_mem[mem_wa] <= itm.seq;
    rd_q <= seq_mem[scan_p_r];
  end

  always_comb begin
    logic              chg, oslot;
    logic [15:0]       aj;
    logic [23:0]       tgt;
    logic [22:0]       tgt_s;
    logic signed [24:0] jdiff, jnew;
    logic [AW-1:0]     bh;
    logic [FW-1:0]     bf;
    logic [39:0]       t1, t3, t5, t8, lv;
    logic [2:0]        q;
    bst_t              after_lvl, after_loss;

    st_nxt = st_r; cur_seq_nxt = cur_seq_r; cur_status_nxt = cur_status_r;
    ssrc_valid_nxt = ssrc_valid_r; ssrc_nxt = ssrc_r; ewma_nxt = ewma_r;
    total_nxt = total_r; win_rx_nxt = win_rx_r; win_lost_nxt = win_lost_r;
    chk_rx_nxt = chk_rx_r; chk_lost_nxt = chk_lost_r; tick_nxt = tick_r; m5_nxt = m5_r;
    level_nxt = level_r; inact_nxt = inact_r; ev_lvl0_nxt = ev_lvl0_r; ev_in0_nxt = ev_in0_r;
    head_nxt = head_r; fill_nxt = fill_r; scan_p_nxt = scan_p_r; scan_k_nxt = scan_k_r;
    scan_pv_nxt = scan_pv_r; ev_nxt = ev_r; l100_nxt = l100_r; tot_nxt = tot_r;
    pct_nxt = pct_r; jthr_nxt = jthr_r; jper_nxt = jper_r; lthr_nxt = lthr_r; lper_nxt = lper_r;
    out_valid_nxt = out_valid_r; out_last_nxt = out_last_r; out_kind_nxt = out_kind_r;
    out_lvl_nxt = out_lvl_r; out_inact_nxt = out_inact_r; out_loss_nxt = out_loss_r;
    out_jit_nxt = out_jit_r;
    mem_we = 1'b0; mem_wa = head_r; itm_pop = 1'b0;
    div_start = 1'b0; div_nd = {16'b0, tick_r}; div_ds = '0;

    oslot = !out_valid_r || !out_stall;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    // absolute jitter into the average's fixed point, saturated
    aj    = itm.jitter[15] ? (~itm.jitter + 16'd1) : itm.jitter;
    tgt   = {aj, 8'b0};
    tgt_s = (tgt > {1'b0, JITTER_MAX}) ? JITTER_MAX : tgt[22:0];
    jdiff = $signed({2'b0, tgt_s}) - $signed({2'b0, ewma_r});
    jnew  = $signed({2'b0, ewma_r}) + (jdiff >>> 4);
    chg   = ssrc_valid_r && (itm.ssrc != ssrc_r);
    bh    = chg ? '0 : head_r;
    bf    = chg ? '0 : fill_r;

    t1 = {7'b0, tot_r};
    t3 = t1 + {t1[38:0], 1'b0};
    t5 = t1 + {t1[37:0], 2'b0};
    t8 = {t1[36:0], 3'b0};
    lv = {1'b0, l100_r};
    priority if (lv < t1) q = 3'd0;
    else if (lv < t3)     q = 3'd1;
    else if (lv < t5)     q = 3'd2;
    else if (lv < t8)     q = 3'd3;
    else                  q = 3'd4;

    after_loss = (jper_r != 16'd0) ? ST_JM_GO : ST_EMIT;
    after_lvl  = (lper_r != 16'd0) ? ST_LM_GO : after_loss;

    unique case (st_r)
      ST_IDLE: begin
        if (itm_valid) begin
          itm_pop        = 1'b1;
          ev_nxt         = '0;
          cur_seq_nxt    = itm.seq;
          cur_status_nxt = itm.status;
          unique case (itm.op)
            OP_RX: begin
              if (chg) begin
                ev_nxt[0]    = 1'b1;
                ev_lvl0_nxt  = level_r;
                ev_in0_nxt   = inact_r;
                tick_nxt     = '0;
                m5_nxt       = '0;
                level_nxt    = LEVEL_UNSET;
                inact_nxt    = 1'b0;
                win_rx_nxt   = '0;
                win_lost_nxt = '0;
                chk_lost_nxt = '0;
              end
              total_nxt      = chg ? 32'd1 : sat_add(total_r, 32'd1);
              chk_rx_nxt     = chg ? 32'd1 : sat_add(chk_rx_r, 32'd1);
              ewma_nxt       = (!ssrc_valid_r || chg) ? tgt_s : jnew[22:0];
              ssrc_nxt       = itm.ssrc;
              ssrc_valid_nxt = 1'b1;
              mem_we         = 1'b1;
              mem_wa         = bh;
              head_nxt       = (bh == AW'(SEQ_STORE_DEPTH - 1)) ? '0 : bh + 1'b1;
              fill_nxt       = (bf < FW'(KEEP)) ? bf + 1'b1 : bf;
              st_nxt         = chg ? ST_EMIT : ST_IDLE;
            end
            OP_GAP: begin
              win_lost_nxt = sat_add(win_lost_r, {16'b0, itm.gap});
              chk_lost_nxt = sat_add(chk_lost_r, {16'b0, itm.gap});
            end
            OP_STATUS: begin
              if (fill_r != '0) begin
                scan_p_nxt  = ptr_dec(head_r);
                scan_k_nxt  = '0;
                scan_pv_nxt = 1'b0;
                st_nxt      = ST_SCAN;
              end
            end
            OP_TICK: begin
              tick_nxt = tick_r + 32'd1;
              // tick count modulo the quality period, also right across the wrap
              m5_nxt   = (tick_r == '1 || m5_r == QUALITY_PERIOD - 3'd1) ? 3'd0
                                                                        : m5_r + 3'd1;
              if (tick_r + 32'd1 == INACT_TICK && total_r == '0) begin
                inact_nxt   = 1'b1;
                ev_nxt[0]   = 1'b1;
                ev_lvl0_nxt = level_r;
                ev_in0_nxt  = 1'b1;
              end
              st_nxt = ST_M5_GO;
            end
          endcase
        end
      end
      ST_SCAN: begin
        // newest first; read data arrives in the cycle after its address
        if (scan_pv_r && rd_q == cur_seq_r) begin
          if (cur_status_r < FST_OTHER) win_rx_nxt = sat_add(win_rx_r, 32'd1);
          st_nxt = ST_IDLE;
        end else if (scan_k_r < fill_r) begin
          scan_p_nxt  = ptr_dec(scan_p_r);
          scan_k_nxt  = scan_k_r + 1'b1;
          scan_pv_nxt = 1'b1;
        end else if (scan_pv_r) begin
          scan_pv_nxt = 1'b0;
        end else begin
          st_nxt = ST_IDLE;
        end
      end
      ST_M5_GO: begin
        if (m5_r == '0) begin
          l100_nxt = (win_rx_r == '0) ? '0 : win_lost_r * 7'd100;
          tot_nxt  = (win_rx_r == '0) ? 33'd1 : {1'b0, win_lost_r} + {1'b0, win_rx_r};
          st_nxt   = ST_LVL;
        end else begin
          st_nxt = after_lvl;
        end
      end
      ST_LVL: begin
        if (q != level_r) begin
          level_nxt = q;
          ev_nxt[1] = 1'b1;
        end
        win_rx_nxt   = '0;
        win_lost_nxt = '0;
        st_nxt       = after_lvl;
      end
      ST_LM_GO: begin
        div_start = 1'b1;
        div_ds    = {17'b0, lper_r};
        st_nxt    = ST_LM_WAIT;
      end
      ST_LM_WAIT: begin
        if (div_done) begin
          if (div_rem != '0) begin
            st_nxt = after_loss;
          end else if (chk_lost_r == '0) begin
            pct_nxt = '0;
            if (lthr_r == '0) ev_nxt[2] = 1'b1;
            chk_rx_nxt   = '0;
            chk_lost_nxt = '0;
            st_nxt       = after_loss;
          end else begin
            st_nxt = ST_LD_GO;
          end
        end
      end
      ST_LD_GO: begin
        div_start = 1'b1;
        div_nd    = {1'b0, loss_prod};
        div_ds    = {1'b0, chk_lost_r} + {1'b0, chk_rx_r};
        st_nxt    = ST_LD_WAIT;
      end
      ST_LD_WAIT: begin
        if (div_done) begin
          pct_nxt = div_quo[14:0];
          if (div_quo[14:0] >= {lthr_r, 8'b0}) ev_nxt[2] = 1'b1;
          chk_rx_nxt   = '0;
          chk_lost_nxt = '0;
          st_nxt       = after_loss;
        end
      end
      ST_JM_GO: begin
        div_start = 1'b1;
        div_ds    = {17'b0, jper_r};
        st_nxt    = ST_JM_WAIT;
      end
      ST_JM_WAIT: begin
        if (div_done) begin
          if (div_rem == '0 && {1'b0, ewma_r} >= {jthr_r, 8'b0}) ev_nxt[3] = 1'b1;
          st_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (ev_r == '0) begin
          st_nxt = ST_IDLE;
        end else if (oslot) begin
          out_valid_nxt = 1'b1;
          out_lvl_nxt   = level_r;
          out_inact_nxt = inact_r;
          out_loss_nxt  = '0;
          out_jit_nxt   = '0;
          priority if (ev_r[0]) begin
            out_kind_nxt  = EV_QUALITY;
            out_lvl_nxt   = ev_lvl0_r;
            out_inact_nxt = ev_in0_r;
            ev_nxt        = ev_r & 4'b1110;
          end else if (ev_r[1]) begin
            out_kind_nxt = EV_QUALITY;
            ev_nxt       = ev_r & 4'b1100;
          end else if (ev_r[2]) begin
            out_kind_nxt = EV_LOSS;
            out_loss_nxt = pct_r;
            ev_nxt       = ev_r & 4'b1000;
          end else begin
            out_kind_nxt = EV_JITTER;
            out_jit_nxt  = ewma_r;
            ev_nxt       = '0;
          end
          out_last_nxt = (ev_nxt == '0);
          if (ev_nxt == '0) st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_JIT_THR: begin
          jthr_nxt = cfg_wdata;
          ewma_nxt = '0;
        end
        CFG_JIT_PER: jper_nxt = cfg_wdata;
        CFG_LOSS_THR: lthr_nxt = cfg_wdata[6:0];
        CFG_LOSS_PER: begin
          lper_nxt     = cfg_wdata;
          chk_rx_nxt   = '0;
          chk_lost_nxt = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    cur_seq_r <= cur_seq_nxt; cur_status_r <= cur_status_nxt;
    ev_lvl0_r <= ev_lvl0_nxt; ev_in0_r <= ev_in0_nxt;
    scan_p_r <= scan_p_nxt; scan_k_r <= scan_k_nxt;
    l100_r <= l100_nxt; tot_r <= tot_nxt; pct_r <= pct_nxt;
    out_last_r <= out_last_nxt; out_kind_r <= out_kind_nxt; out_lvl_r <= out_lvl_nxt;
    out_inact_r <= out_inact_nxt; out_loss_r <= out_loss_nxt; out_jit_r <= out_jit_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; ssrc_valid_r <= 1'b0; ssrc_r <= '0; ewma_r <= '0;
      total_r <= '0; win_rx_r <= '0; win_lost_r <= '0; chk_rx_r <= '0; chk_lost_r <= '0;
      tick_r <= '0; m5_r <= '0; level_r <= LEVEL_UNSET; inact_r <= 1'b0;
      head_r <= '0; fill_r <= '0; scan_pv_r <= 1'b0; ev_r <= '0;
      jthr_r <= '0; jper_r <= '0; lthr_r <= '0; lper_r <= '0; out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt; ssrc_valid_r <= ssrc_valid_nxt; ssrc_r <= ssrc_nxt; ewma_r <= ewma_nxt;
      total_r <= total_nxt; win_rx_r <= win_rx_nxt; win_lost_r <= win_lost_nxt;
      chk_rx_r <= chk_rx_nxt; chk_lost_r <= chk_lost_nxt;
      tick_r <= tick_nxt; m5_r <= m5_nxt; level_r <= level_nxt; inact_r <= inact_nxt;
      head_r <= head_nxt; fill_r <= fill_nxt; scan_pv_r <= scan_pv_nxt; ev_r <= ev_nxt;
      jthr_r <= jthr_nxt; jper_r <= jper_nxt; lthr_r <= lthr_nxt; lper_r <= lper_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_event_kind     = out_kind_r;
  assign out_quality_level  = out_lvl_r;
  assign out_inactivity     = out_inact_r;
  assign out_loss_percent   = out_loss_r;
  assign out_jitter_average = out_jit_r;
  assign out_last           = out_last_r;

endmodule

// File: sv/rtp_stream_quality_monitor.sv
// RTP receive stream quality monitor.
// Input channel (in_valid / in_stall) carries one item per transfer: a received
// packet, a loss-gap report, a playout status lookup or a one-second tick.
// Result channel (out_valid / out_stall) carries quality reports and loss and
// jitter alerts; out_last marks the final result caused by an input item.
// Configuration is a write-only port (cfg_we, cfg_index, cfg_wdata); the user
// must use it only while the block is idle, which the block does not enforce.
// Items enter a two-entry queue, so two more transfers are taken while the
// back end works. Gap reports and packets are handled in the idle state, and
// a packet that changes the SSRC also emits a report. A status lookup walks
// the sequence ring newest first, one entry a cycle (fill at most 499). On a
// tick, grading every fifth tick uses a small modulo-5 counter, while the loss
// and jitter period checks and the loss-percent division each take a pass on
// a shared 48-step serial divider; the tick's results then leave one per cycle
// while the output is not stalled.
// Results sit in an output register; a stalled result holds and the back end
// waits on it, while the front queue keeps taking items until full.
// Reset (synchronous, rst_n low) clears statistics, control state and the queue;
// the sequence store needs no clearing pass.
module rtp_stream_quality_monitor #(
  parameter int SEQ_STORE_DEPTH = 512
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_opcode,
  input  logic [31:0]        in_packet_ssrc,
  input  logic signed [15:0] in_packet_jitter,
  input  logic [1:0]         in_data_type,
  input  logic [15:0]        in_gap_count,
  input  logic [15:0]        in_seq_number,
  input  logic [2:0]         in_frame_status,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_wdata,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_event_kind,
  output logic [2:0]         out_quality_level,
  output logic               out_inactivity,
  output logic [14:0]        out_loss_percent,
  output logic [22:0]        out_jitter_average,
  output logic               out_last
);
  import rsqm_pkg::*;

  item_t itm;
  logic  itm_valid, itm_pop;

  // data type carries no meaning for any result
  rsqm_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_packet_ssrc   (in_packet_ssrc),
    .in_packet_jitter (in_packet_jitter),
    .in_gap_count     (in_gap_count),
    .in_seq_number    (in_seq_number),
    .in_frame_status  (in_frame_status),
    .itm_valid        (itm_valid),
    .itm_pop          (itm_pop),
    .itm              (itm)
  );

  rsqm_back #(.SEQ_STORE_DEPTH(SEQ_STORE_DEPTH)) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .itm_valid          (itm_valid),
    .itm_pop            (itm_pop),
    .itm                (itm),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_event_kind     (out_event_kind),
    .out_quality_level  (out_quality_level),
    .out_inactivity     (out_inactivity),
    .out_loss_percent   (out_loss_percent),
    .out_jitter_average (out_jitter_average),
    .out_last           (out_last)
  );

endmodule

// File: sv/rsqm_checker.sv
module rsqm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_event_kind,
  input logic [14:0] out_loss_percent,
  input logic [22:0] out_jitter_average
);
  import rsqm_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown after reset");

  a_loss_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind == EV_LOSS |-> out_loss_percent <= LOSS_SCALE
      && out_jitter_average == 23'd0)
    else $error("loss alert out of range");

  a_report_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind == EV_QUALITY |->
      out_loss_percent == 15'd0 && out_jitter_average == 23'd0)
    else $error("quality report carries alert data");

  a_jitter_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind == EV_JITTER |-> out_loss_percent == 15'd0)
    else $error("jitter alert carries loss data");

endmodule

bind rtp_stream_quality_monitor rsqm_checker u_chk (.*);
